// File: src/assert_macros.svh
// assertion macros used by the checker file fisr_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge, switched off while reset is asserted
`define FISR_ASSERT(lbl, prp, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prp) else $error(msg);

// checked at every clock edge, reset included
`define FISR_ASSERT_ALWAYS(lbl, prp, msg) \
	lbl: assert property (@(posedge clk) prp) else $error(msg);

`endif

// File: src/fisr_pkg.sv
package fisr_pkg;

	// one beat on a float lane: valid bit plus single-precision pattern
	typedef struct packed {
		logic        valid;
		logic [31:0] bits;
	} flt_beat_t;

	localparam logic [31:0] GUESS_MAGIC  = 32'h5f3759df;
	localparam logic [31:0] HALF_BITS    = 32'h3f000000;
	localparam logic [31:0] THREE_HALVES = 32'h3fc00000;
	localparam logic [31:0] CANON_NAN    = 32'h7fc00000;

	// register stages of the arithmetic units
	localparam int MUL_LAT  = 3;
	localparam int ADD_LAT  = 3;
	localparam int STEP_LAT = 3 * MUL_LAT + ADD_LAT;

	// leading zero count of a 48-bit word, 48 when all zero
	function automatic logic [5:0] lead_zeros(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) begin
				n = 6'(47 - i);
			end
		end
		return n;
	endfunction

endpackage

// File: src/fisr_fmul.sv
module fisr_fmul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [31:0]         a,
	input  logic [31:0]         b,
	output fisr_pkg::flt_beat_t res
);

	// stage 1: unpack and multiply significands
	logic [7:0]         ea, eb, eea, eeb;
	logic [23:0]        ma, mb;
	logic               a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;

	assign ea     = a[30:23];
	assign eb     = b[30:23];
	assign eea    = (ea == 8'd0) ? 8'd1 : ea;
	assign eeb    = (eb == 8'd0) ? 8'd1 : eb;
	assign ma     = {ea != 8'd0, a[22:0]};
	assign mb     = {eb != 8'd0, b[22:0]};
	assign a_zero = (ea == 8'd0) && (a[22:0] == 23'd0);
	assign b_zero = (eb == 8'd0) && (b[22:0] == 23'd0);
	assign a_inf  = (ea == 8'hff) && (a[22:0] == 23'd0);
	assign b_inf  = (eb == 8'hff) && (b[22:0] == 23'd0);
	assign a_nan  = (ea == 8'hff) && (a[22:0] != 23'd0);
	assign b_nan  = (eb == 8'hff) && (b[22:0] != 23'd0);

	logic               v_s1, sign_s1, nan_s1, inf_s1, zero_s1;
	logic signed [10:0] ebase_s1;
	logic [47:0]        p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sign_s1  <= a[31] ^ b[31];
		nan_s1   <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
		inf_s1   <= a_inf | b_inf;
		zero_s1  <= a_zero | b_zero;
		ebase_s1 <= $signed({3'b000, eea}) + $signed({3'b000, eeb}) - 11'sd126;
		p_s1     <= ma * mb;
	end

	// stage 2: leading zeros, result exponent and shift amount
	logic [5:0]         lz;
	logic signed [10:0] er, sh;

	assign lz = fisr_pkg::lead_zeros(p_s1);
	assign er = ebase_s1 - $signed({5'b00000, lz});
	assign sh = (er >= 11'sd1) ? $signed({5'b00000, lz})
	                           : $signed({5'b00000, lz}) + er - 11'sd1;

	logic               v_s2, sign_s2, nan_s2, inf_s2, zero_s2, ovf_s2;
	logic signed [10:0] sh_s2;
	logic [7:0]         ef_s2;
	logic [47:0]        p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sign_s2 <= sign_s1;
		nan_s2  <= nan_s1;
		inf_s2  <= inf_s1;
		zero_s2 <= zero_s1;
		ovf_s2  <= (er >= 11'sd255);
		sh_s2   <= sh;
		ef_s2   <= (er >= 11'sd1) ? er[7:0] : 8'd0;
		p_s2    <= p_s1;
	end

	// stage 3: normalize or denormalize, round to nearest even, pack
	logic signed [10:0] rs;
	logic [5:0]         rsc;
	logic [111:0]       wide;
	logic [47:0]        q;
	logic               stk, rnd;
	logic [30:0]        mag;
	logic [31:0]        rbits;
	logic               v_s3;
	logic [31:0]        bits_s3;

	assign rs   = -sh_s2;
	assign rsc  = (rs > 11'sd63) ? 6'd63 : rs[5:0];
	assign wide = {p_s2, 64'd0} >> rsc;

	always_comb begin
		if (sh_s2 >= 11'sd0) begin
			q   = p_s2 << sh_s2[5:0];
			stk = 1'b0;
		end else begin
			q   = wide[111:64];
			stk = |wide[63:0];
		end
	end

	assign rnd = q[23] & ((|q[22:0]) | stk | q[24]);
	assign mag = {ef_s2, q[46:24]} + {30'd0, rnd};

	always_comb begin
		if (nan_s2) begin
			rbits = fisr_pkg::CANON_NAN;
		end else if (inf_s2 || ovf_s2) begin
			rbits = {sign_s2, 8'hff, 23'd0};
		end else if (zero_s2) begin
			rbits = {sign_s2, 31'd0};
		end else begin
			rbits = {sign_s2, mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		bits_s3 <= rbits;
	end

	assign res = {v_s3, bits_s3};

endmodule

// File: src/fisr_fadd.sv
module fisr_fadd (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [31:0]         a,
	input  logic [31:0]         b,
	output fisr_pkg::flt_beat_t res
);

	// stage 1: unpack, order by magnitude, exponent difference
	logic [7:0]  ea, eb, eea, eeb;
	logic [23:0] ma, mb;
	logic        a_inf, b_inf, a_nan, b_nan, a_big;

	assign ea    = a[30:23];
	assign eb    = b[30:23];
	assign eea   = (ea == 8'd0) ? 8'd1 : ea;
	assign eeb   = (eb == 8'd0) ? 8'd1 : eb;
	assign ma    = {ea != 8'd0, a[22:0]};
	assign mb    = {eb != 8'd0, b[22:0]};
	assign a_inf = (ea == 8'hff) && (a[22:0] == 23'd0);
	assign b_inf = (eb == 8'hff) && (b[22:0] == 23'd0);
	assign a_nan = (ea == 8'hff) && (a[22:0] != 23'd0);
	assign b_nan = (eb == 8'hff) && (b[22:0] != 23'd0);
	assign a_big = (a[30:0] >= b[30:0]);

	logic        v_s1, sign_s1, sub_s1, zsign_s1, nan_s1, inf_s1, isign_s1;
	logic [23:0] bm_s1, sm_s1;
	logic [7:0]  d_s1, e_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sign_s1  <= a_big ? a[31] : b[31];
		sub_s1   <= a[31] ^ b[31];
		zsign_s1 <= a[31] & b[31];
		nan_s1   <= a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
		inf_s1   <= a_inf | b_inf;
		isign_s1 <= a_inf ? a[31] : b[31];
		bm_s1    <= a_big ? ma : mb;
		sm_s1    <= a_big ? mb : ma;
		d_s1     <= a_big ? (eea - eeb) : (eeb - eea);
		e_s1     <= a_big ? eea : eeb;
	end

	// stage 2: align the smaller operand and add or subtract
	logic [4:0]  dcap;
	logic [58:0] wide;
	logic [26:0] al;

	assign dcap = (d_s1 > 8'd31) ? 5'd31 : d_s1[4:0];
	assign wide = {sm_s1, 3'b000, 32'd0} >> dcap;
	assign al   = {wide[58:33], wide[32] | (|wide[31:0])};

	logic        v_s2, sign_s2, zsign_s2, nan_s2, inf_s2, isign_s2;
	logic [27:0] sum_s2;
	logic [7:0]  e_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sign_s2  <= sign_s1;
		zsign_s2 <= zsign_s1;
		nan_s2   <= nan_s1;
		inf_s2   <= inf_s1;
		isign_s2 <= isign_s1;
		e_s2     <= e_s1;
		sum_s2   <= sub_s1 ? ({1'b0, bm_s1, 3'b000} - {1'b0, al})
		                   : ({1'b0, bm_s1, 3'b000} + {1'b0, al});
	end

	// stage 3: normalize, round to nearest even, pack
	logic [5:0]  lz;
	logic [7:0]  lim, sh;
	logic [26:0] n;
	logic [8:0]  eres;
	logic [7:0]  ef;
	logic        rnd;
	logic [30:0] mag;
	logic [31:0] rbits;
	logic        v_s3;
	logic [31:0] bits_s3;

	assign lz  = fisr_pkg::lead_zeros({sum_s2[26:0], 21'd0});
	assign lim = e_s2 - 8'd1;
	assign sh  = ({2'b00, lz} > lim) ? lim : {2'b00, lz};

	always_comb begin
		if (sum_s2[27]) begin
			n    = {sum_s2[27:2], sum_s2[1] | sum_s2[0]};
			eres = {1'b0, e_s2} + 9'd1;
		end else begin
			n    = sum_s2[26:0] << sh;
			eres = {1'b0, e_s2} - {1'b0, sh};
		end
	end

	assign ef  = n[26] ? eres[7:0] : 8'd0;
	assign rnd = n[2] & (n[1] | n[0] | n[3]);
	assign mag = {ef, n[25:3]} + {30'd0, rnd};

	always_comb begin
		if (nan_s2) begin
			rbits = fisr_pkg::CANON_NAN;
		end else if (inf_s2) begin
			rbits = {isign_s2, 8'hff, 23'd0};
		end else if (sum_s2 == 28'd0) begin
			rbits = {zsign_s2, 31'd0};
		end else if (eres >= 9'd255) begin
			rbits = {sign_s2, 8'hff, 23'd0};
		end else begin
			rbits = {sign_s2, mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		bits_s3 <= rbits;
	end

	assign res = {v_s3, bits_s3};

endmodule

// File: src/fisr_newton.sv
module fisr_newton (
	input  logic                clk,
	input  logic                arst_n,
	input  fisr_pkg::flt_beat_t y_in,
	input  logic [31:0]         x_in,
	output fisr_pkg::flt_beat_t y_out,
	output logic [31:0]         x_out
);

	localparam int Y_DLY = 2 * fisr_pkg::MUL_LAT + fisr_pkg::ADD_LAT;
	localparam int X_DLY = fisr_pkg::STEP_LAT;

	fisr_pkg::flt_beat_t t1, t2, t3;
	logic [31:0]         y_dly_q [Y_DLY];
	logic [31:0]         x_dly_q [X_DLY];

	// y and x travel beside the arithmetic
	always_ff @(posedge clk) begin
		y_dly_q[0] <= y_in.bits;
		for (int i = 1; i < Y_DLY; i++) begin
			y_dly_q[i] <= y_dly_q[i - 1];
		end
		x_dly_q[0] <= x_in;
		for (int i = 1; i < X_DLY; i++) begin
			x_dly_q[i] <= x_dly_q[i - 1];
		end
	end

	// t = x * y
	fisr_fmul u_mul_xy (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (y_in.valid),
		.a        (x_in),
		.b        (y_in.bits),
		.res      (t1)
	);

	// t = t * y
	fisr_fmul u_mul_ty (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (t1.valid),
		.a        (t1.bits),
		.b        (y_dly_q[fisr_pkg::MUL_LAT - 1]),
		.res      (t2)
	);

	// t = 1.5 - t
	fisr_fadd u_sub (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (t2.valid),
		.a        (fisr_pkg::THREE_HALVES),
		.b        ({~t2.bits[31], t2.bits[30:0]}),
		.res      (t3)
	);

	// y = y * t
	fisr_fmul u_mul_yt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (t3.valid),
		.a        (y_dly_q[Y_DLY - 1]),
		.b        (t3.bits),
		.res      (y_out)
	);

	assign x_out = x_dly_q[X_DLY - 1];

endmodule

// File: src/fast_inverse_square_root.sv
// the operand passes the half multiplier, the refinement steps, the final multiplier and the output register to done
// throughput: one operand per cycle, busy is always low
// the multipliers and adder each have 3 register stages and are chained per refinement step
// results show for one cycle on done and cannot be stalled
// arst_n clears every valid bit at once, data registers are not reset
module fast_inverse_square_root #(
	parameter int NEWTON_STEPS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [31:0] operand_bits,
	output logic        done,
	output logic [31:0] result_bits
);

	localparam int G_DLY  = fisr_pkg::MUL_LAT;
	localparam int N_DLY  = fisr_pkg::MUL_LAT + fisr_pkg::STEP_LAT * NEWTON_STEPS;
	localparam int OP_DLY = N_DLY + fisr_pkg::MUL_LAT;

	fisr_pkg::flt_beat_t xh, sq;
	fisr_pkg::flt_beat_t y_chain [NEWTON_STEPS + 1];
	logic [31:0]         x_chain [NEWTON_STEPS + 1];
	logic [31:0]         guess;
	logic [31:0]         g_dly_q  [G_DLY];
	logic [31:0]         n_dly_q  [N_DLY];
	logic [31:0]         yf_dly_q [fisr_pkg::MUL_LAT];
	logic                op_dly_q [OP_DLY];
	logic                done_q;
	logic [31:0]         result_q;

	assign busy = 1'b0;

	// first guess from the bit pattern
	assign guess = fisr_pkg::GUESS_MAGIC - {operand_bits[31], operand_bits[31:1]};

	// x = number * 0.5
	fisr_fmul u_half (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.a        (operand_bits),
		.b        (fisr_pkg::HALF_BITS),
		.res      (xh)
	);

	// side lanes for guess, operand, op and the final y
	always_ff @(posedge clk) begin
		g_dly_q[0] <= guess;
		for (int i = 1; i < G_DLY; i++) begin
			g_dly_q[i] <= g_dly_q[i - 1];
		end
		n_dly_q[0] <= operand_bits;
		for (int i = 1; i < N_DLY; i++) begin
			n_dly_q[i] <= n_dly_q[i - 1];
		end
		op_dly_q[0] <= op;
		for (int i = 1; i < OP_DLY; i++) begin
			op_dly_q[i] <= op_dly_q[i - 1];
		end
		yf_dly_q[0] <= y_chain[NEWTON_STEPS].bits;
		for (int i = 1; i < fisr_pkg::MUL_LAT; i++) begin
			yf_dly_q[i] <= yf_dly_q[i - 1];
		end
	end

	assign y_chain[0].valid = xh.valid;
	assign y_chain[0].bits  = g_dly_q[G_DLY - 1];
	assign x_chain[0]       = xh.bits;

	// refinement steps
	for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
		fisr_newton u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.y_in   (y_chain[k]),
			.x_in   (x_chain[k]),
			.y_out  (y_chain[k + 1]),
			.x_out  (x_chain[k + 1])
		);
	end

	// square root as number * y
	fisr_fmul u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (y_chain[NEWTON_STEPS].valid),
		.a        (n_dly_q[N_DLY - 1]),
		.b        (y_chain[NEWTON_STEPS].bits),
		.res      (sq)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sq.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= op_dly_q[OP_DLY - 1] ? sq.bits : yf_dly_q[fisr_pkg::MUL_LAT - 1];
	end

	assign done        = done_q;
	assign result_bits = result_q;

endmodule

// File: src/fisr_checker.sv
`include "assert_macros.svh"

module fisr_checker #(
	parameter int NEWTON_STEPS = 3
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] result_bits
);

	localparam int LAT = 2 * fisr_pkg::MUL_LAT + fisr_pkg::STEP_LAT * NEWTON_STEPS + 1;

	// the unit never holds off a beat
	`FISR_ASSERT_ALWAYS(a_never_busy, (busy == 1'b0), "busy raised")
	// no result while reset is applied
	`FISR_ASSERT_ALWAYS(a_quiet_in_reset, (!arst_n |-> !done), "done during reset")
	// every accepted beat gives one result after the fixed latency
	`FISR_ASSERT(a_beat_to_result, (start && !busy |-> ##LAT done), "result missing")
	// every result comes from an accepted beat
	`FISR_ASSERT(a_result_from_beat, (done |-> $past(start && !busy, LAT)), "result invented")
	// a NaN result is always the canonical quiet NaN
	`FISR_ASSERT(a_canon_nan, (done |-> !(result_bits[30:23] == 8'hff && result_bits[22:0] != 23'd0) || result_bits == fisr_pkg::CANON_NAN), "non-canonical NaN")

endmodule

bind fast_inverse_square_root fisr_checker #(.NEWTON_STEPS(NEWTON_STEPS)) u_fisr_checker (.*);
